// File: rtl/touch_gesture_recognizer_unit_macros.svh
// Assertion macros shared by the gesture recognizer RTL.
`ifndef TOUCH_GESTURE_RECOGNIZER_UNIT_MACROS_SVH
`define TOUCH_GESTURE_RECOGNIZER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TGR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tgr_pkg.sv
// Types and constants of the touch gesture recognizer.
package tgr_pkg;

   localparam int REG_W     = 16;
   localparam int LIMIT_W   = 8;
   localparam int CNT_W     = 8;
   localparam int TICK_W    = 32;
   localparam int KIND_W    = 3;
   localparam int CSR_IDX_W = 8;

   localparam logic [REG_W-1:0]   CLICK_MAX_RST = 16'd150;
   localparam logic [REG_W-1:0]   FLING_TPP_RST = 16'd10;
   localparam logic [LIMIT_W-1:0] MOVE_LIM_RST  = 8'd3;
   localparam logic [REG_W-1:0]   GAP_RST       = 16'd300;
   localparam logic [CNT_W-1:0]   CNT_MAX       = 8'hFF;

   typedef enum logic [KIND_W-1:0] {
      EV_DOWN  = 3'd0,
      EV_HOLD  = 3'd1,
      EV_MOVE  = 3'd2,
      EV_FLING = 3'd3,
      EV_CLICK = 3'd4,
      EV_UP    = 3'd5
   } event_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLICK_MAX = 8'd0,
      CSR_FLING_TPP = 8'd1,
      CSR_MOVE_LIM  = 8'd2,
      CSR_GAP       = 8'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_MUL,
      ST_DECIDE,
      ST_EMIT_A,
      ST_EMIT_B
   } state_type;

endpackage

// File: rtl/tgr_interfaces.sv
// Handshake channel interfaces of the touch gesture recognizer.
interface tgr_req_if #(parameter int COORD_BITS = 12);
   logic                            valid;
   logic                            ready;
   logic                            pressed;
   logic signed [COORD_BITS-1:0]    pos_x;
   logic signed [COORD_BITS-1:0]    pos_y;
   logic [tgr_pkg::TICK_W-1:0]      now_tick;

   modport source (output valid, pressed, pos_x, pos_y, now_tick, input ready);
   modport sink   (input valid, pressed, pos_x, pos_y, now_tick, output ready);
endinterface

interface tgr_rsp_if #(parameter int COORD_BITS = 12);
   logic                            valid;
   logic                            ready;
   logic [tgr_pkg::KIND_W-1:0]      event_kind;
   logic signed [COORD_BITS-1:0]    start_x;
   logic signed [COORD_BITS-1:0]    start_y;
   logic signed [COORD_BITS-1:0]    point_x;
   logic signed [COORD_BITS-1:0]    point_y;
   logic [tgr_pkg::CNT_W-1:0]       click_count;
   logic [tgr_pkg::TICK_W-1:0]      elapsed;
   logic                            last_of_run;

   modport source (output valid, event_kind, start_x, start_y, point_x, point_y,
                   click_count, elapsed, last_of_run, input ready);
   modport sink   (input valid, event_kind, start_x, start_y, point_x, point_y,
                   click_count, elapsed, last_of_run, output ready);
endinterface

interface tgr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tgr_pkg::CSR_IDX_W-1:0]   index;
   logic [tgr_pkg::REG_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/tgr_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module tgr_mul #(
   parameter int A_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [A_BITS-1:0]                mplier,
   input  logic [tgr_pkg::REG_W-1:0]        mcand,
   output logic                             busy,
   output logic                             done,
   output logic [A_BITS+tgr_pkg::REG_W-1:0] product
);
   localparam int PW = A_BITS + tgr_pkg::REG_W;
   localparam int CW = $clog2(A_BITS + 1);

   logic [PW-1:0]     acc_ff;
   logic [PW-1:0]     acc_in;
   logic [PW-1:0]     mcand_ff;
   logic [A_BITS-1:0] mplier_ff;
   logic [CW-1:0]     cnt_ff;
   logic              done_ff;

   // add the shifted multiplicand when the current multiplier bit is set
   assign acc_in = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CW'(1));
         if (start) begin
            cnt_ff <= CW'(A_BITS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= PW'(mcand);
         mplier_ff <= mplier;
      end else if (cnt_ff != '0) begin
         acc_ff    <= acc_in;
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
      end
   end

   assign busy    = (cnt_ff != '0);
   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// File: rtl/touch_gesture_recognizer_unit.sv
// Touch gesture recognizer top level: sequencer, gesture state and result beats.
//
// Turns touch samples (press flag, position, tick) into gesture beats: down on a
// press edge, hold while pressed (preceded by move once enough slow moves were
// seen), and up on release, after a click, fling or move where one applies.
// Distance is the larger of |dx| and |dy| from the anchor point. The fast-movement
// test elapsed/distance < fling_ticks_per_pixel is evaluated as
// elapsed < fling_ticks_per_pixel * distance on a shift-add multiplier that
// retires one distance bit per cycle. A sample is taken only when the block is
// idle: it is captured, elapsed time and distance are formed, the product is
// computed in the multiplier (skipped for a press edge or a zero distance), the
// sample is decided, then one beat per result follows, each beat held until the
// sink takes it. A release while already released gives no beat and returns to
// idle from the calculation step. Configuration writes are taken at any
// time (ready is always high) and should only be issued while idle; an index
// beyond the register list is ignored.
`include "touch_gesture_recognizer_unit_macros.svh"

module touch_gesture_recognizer_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic   clock,
   input  logic   reset,
   tgr_req_if.sink   req_chan,
   tgr_rsp_if.source rsp_chan,
   tgr_csr_if.sink   csr_chan
);
   localparam int CB    = COORD_BITS;
   localparam int PW    = CB + tgr_pkg::REG_W;
   localparam int CMP_W = (PW > tgr_pkg::TICK_W) ? PW : tgr_pkg::TICK_W;
   localparam int TW    = tgr_pkg::TICK_W;
   localparam int NW    = tgr_pkg::CNT_W;

   // configuration registers
   logic [tgr_pkg::REG_W-1:0]   click_max_ff;
   logic [tgr_pkg::REG_W-1:0]   fling_tpp_ff;
   logic [tgr_pkg::LIMIT_W-1:0] move_lim_ff;
   logic [tgr_pkg::REG_W-1:0]   gap_ff;

   // gesture state
   logic                 touch_down_ff;
   logic signed [CB-1:0] anchor_x_ff;
   logic signed [CB-1:0] anchor_y_ff;
   logic [TW-1:0]        edge_tick_ff;
   logic [NW-1:0]        clicks_ff;
   logic [NW-1:0]        slow_ff;

   // captured sample and derived values
   logic                 pressed_ff;
   logic signed [CB-1:0] px_ff;
   logic signed [CB-1:0] py_ff;
   logic [TW-1:0]        now_ff;
   logic [TW-1:0]        el_ff;
   logic [CB-1:0]        dist_ff;
   logic [CB-1:0]        dist_in;
   logic                 fast_ff;

   // result beat registers
   tgr_pkg::event_kind_type out_kind_ff;
   logic signed [CB-1:0]    out_sx_ff;
   logic signed [CB-1:0]    out_sy_ff;
   logic [NW-1:0]           out_cnt_ff;
   logic [TW-1:0]           out_el_ff;
   logic                    out_last_ff;
   tgr_pkg::event_kind_type pend_kind_ff;
   logic [NW-1:0]           pend_cnt_ff;
   logic [TW-1:0]           pend_el_ff;
   logic                    two_ff;

   tgr_pkg::state_type state_ff;
   tgr_pkg::state_type state_in;

   // sequencer outputs
   logic req_take;
   logic rsp_take;
   logic mul_start;
   logic do_decide;

   // multiplier
   logic          mul_busy;
   logic          mul_done;
   logic [PW-1:0] mul_product;

   // distance: max of the absolute coordinate differences
   logic signed [CB:0] diff_x;
   logic signed [CB:0] diff_y;
   logic [CB:0]        abs_x;
   logic [CB:0]        abs_y;

   // decision
   logic                    dist_nz;
   logic [NW-1:0]           clicks_inc;
   logic [NW-1:0]           slow_next;
   logic                    has_pre;
   tgr_pkg::event_kind_type pre_kind;
   logic                    pre_start;
   logic [NW-1:0]           pre_cnt;
   tgr_pkg::event_kind_type fin_kind;
   logic [NW-1:0]           fin_cnt;
   logic [TW-1:0]           fin_el;

   assign diff_x  = {anchor_x_ff[CB-1], anchor_x_ff} - {px_ff[CB-1], px_ff};
   assign diff_y  = {anchor_y_ff[CB-1], anchor_y_ff} - {py_ff[CB-1], py_ff};
   assign abs_x   = diff_x[CB] ? (CB+1)'(-diff_x) : diff_x;
   assign abs_y   = diff_y[CB] ? (CB+1)'(-diff_y) : diff_y;
   assign dist_in = (abs_x > abs_y) ? abs_x[CB-1:0] : abs_y[CB-1:0];

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;

   tgr_mul #(
      .A_BITS (CB)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mplier  (dist_in),
      .mcand   (fling_tpp_ff),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_product)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tgr_pkg::ST_IDLE: begin
            if (req_take) state_in = tgr_pkg::ST_CALC;
         end
         tgr_pkg::ST_CALC: begin
            if (!pressed_ff && !touch_down_ff) begin
               state_in = tgr_pkg::ST_IDLE;   // release while released: drop
            end else if (touch_down_ff && dist_in != '0) begin
               state_in = tgr_pkg::ST_MUL;
            end else begin
               state_in = tgr_pkg::ST_DECIDE;
            end
         end
         tgr_pkg::ST_MUL: begin
            if (mul_done) state_in = tgr_pkg::ST_DECIDE;
         end
         tgr_pkg::ST_DECIDE: state_in = tgr_pkg::ST_EMIT_A;
         tgr_pkg::ST_EMIT_A: begin
            if (rsp_take) state_in = two_ff ? tgr_pkg::ST_EMIT_B : tgr_pkg::ST_IDLE;
         end
         tgr_pkg::ST_EMIT_B: begin
            if (rsp_take) state_in = tgr_pkg::ST_IDLE;
         end
         default: state_in = tgr_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      mul_start      = 1'b0;
      do_decide      = 1'b0;
      case (state_ff)
         tgr_pkg::ST_IDLE:   req_chan.ready = 1'b1;
         tgr_pkg::ST_CALC:   mul_start = touch_down_ff && (dist_in != '0);
         tgr_pkg::ST_MUL:    mul_start = 1'b0;
         tgr_pkg::ST_DECIDE: do_decide = 1'b1;
         tgr_pkg::ST_EMIT_A: rsp_chan.valid = 1'b1;
         tgr_pkg::ST_EMIT_B: rsp_chan.valid = 1'b1;
         default:            req_chan.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tgr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // decision for the sample; fast_ff only counts when the distance is nonzero
   assign dist_nz    = (dist_ff != '0);
   assign clicks_inc = (clicks_ff != tgr_pkg::CNT_MAX) ? clicks_ff + NW'(1) : clicks_ff;
   assign slow_next  = (dist_nz && !fast_ff && (slow_ff <= move_lim_ff) &&
                        (slow_ff != tgr_pkg::CNT_MAX)) ? slow_ff + NW'(1) : slow_ff;

   always_comb begin
      has_pre   = 1'b0;
      pre_kind  = tgr_pkg::EV_MOVE;
      pre_start = 1'b0;
      pre_cnt   = '0;
      fin_kind  = tgr_pkg::EV_HOLD;
      fin_cnt   = '0;
      fin_el    = '0;
      if (!pressed_ff) begin
         // release: click, fling or move, then up
         fin_kind = tgr_pkg::EV_UP;
         fin_cnt  = clicks_inc;
         if (el_ff < TW'(click_max_ff)) begin
            has_pre  = 1'b1;
            pre_kind = tgr_pkg::EV_CLICK;
            pre_cnt  = clicks_inc;
         end else if ((slow_ff < move_lim_ff) && dist_nz && fast_ff) begin
            has_pre   = 1'b1;
            pre_kind  = tgr_pkg::EV_FLING;
            pre_start = 1'b1;
         end else if (dist_nz) begin
            has_pre   = 1'b1;
            pre_kind  = tgr_pkg::EV_MOVE;
            pre_start = 1'b1;
         end
      end else if (!touch_down_ff) begin
         fin_kind = tgr_pkg::EV_DOWN;
         fin_el   = el_ff;
      end else begin
         fin_kind = tgr_pkg::EV_HOLD;
         fin_el   = el_ff;
         if (dist_nz && (slow_next >= move_lim_ff)) begin
            has_pre   = 1'b1;
            pre_kind  = tgr_pkg::EV_MOVE;
            pre_start = 1'b1;
         end
      end
   end

   // configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         click_max_ff <= tgr_pkg::CLICK_MAX_RST;
         fling_tpp_ff <= tgr_pkg::FLING_TPP_RST;
         move_lim_ff  <= tgr_pkg::MOVE_LIM_RST;
         gap_ff       <= tgr_pkg::GAP_RST;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            tgr_pkg::CSR_CLICK_MAX: click_max_ff <= csr_chan.data;
            tgr_pkg::CSR_FLING_TPP: fling_tpp_ff <= csr_chan.data;
            tgr_pkg::CSR_MOVE_LIM:  move_lim_ff  <= csr_chan.data[tgr_pkg::LIMIT_W-1:0];
            tgr_pkg::CSR_GAP:       gap_ff       <= csr_chan.data;
            default:                gap_ff       <= gap_ff;   // drop unknown index
         endcase
      end
   end

   // gesture state: updated at most once per sample, in the decide cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         touch_down_ff <= 1'b0;
         anchor_x_ff   <= '0;
         anchor_y_ff   <= '0;
         edge_tick_ff  <= '0;
         clicks_ff     <= '0;
         slow_ff       <= '0;
      end else if (do_decide) begin
         if (!pressed_ff) begin
            touch_down_ff <= 1'b0;
            clicks_ff     <= clicks_inc;
            edge_tick_ff  <= now_ff;
         end else if (!touch_down_ff) begin
            touch_down_ff <= 1'b1;
            anchor_x_ff   <= px_ff;
            anchor_y_ff   <= py_ff;
            slow_ff       <= '0;
            edge_tick_ff  <= now_ff;
            if (el_ff > TW'(gap_ff)) clicks_ff <= '0;
         end else begin
            slow_ff <= slow_next;
            if (has_pre) begin
               anchor_x_ff <= px_ff;   // move re-anchors at the current point
               anchor_y_ff <= py_ff;
            end
         end
      end
   end

   // sample capture, elapsed time, distance and fast-move flag
   always_ff @(posedge clock) begin
      if (req_take) begin
         pressed_ff <= req_chan.pressed;
         px_ff      <= req_chan.pos_x;
         py_ff      <= req_chan.pos_y;
         now_ff     <= req_chan.now_tick;
      end
      if (state_ff == tgr_pkg::ST_CALC) begin
         el_ff   <= now_ff - edge_tick_ff;
         dist_ff <= dist_in;
         fast_ff <= 1'b0;
      end else if (mul_done) begin
         fast_ff <= CMP_W'(el_ff) < CMP_W'(mul_product);
      end
   end

   // result beats: first beat in out_*, the trailing up or hold waits in pend_*
   always_ff @(posedge clock) begin
      if (reset) begin
         two_ff <= 1'b0;
      end else if (do_decide) begin
         two_ff <= has_pre;
      end
   end

   always_ff @(posedge clock) begin
      if (do_decide) begin
         pend_kind_ff <= fin_kind;
         pend_cnt_ff  <= fin_cnt;
         pend_el_ff   <= fin_el;
         if (has_pre) begin
            out_kind_ff <= pre_kind;
            out_sx_ff   <= pre_start ? anchor_x_ff : '0;
            out_sy_ff   <= pre_start ? anchor_y_ff : '0;
            out_cnt_ff  <= pre_cnt;
            out_el_ff   <= '0;
            out_last_ff <= 1'b0;
         end else begin
            out_kind_ff <= fin_kind;
            out_sx_ff   <= '0;
            out_sy_ff   <= '0;
            out_cnt_ff  <= fin_cnt;
            out_el_ff   <= fin_el;
            out_last_ff <= 1'b1;
         end
      end else if (rsp_take && state_ff == tgr_pkg::ST_EMIT_A && two_ff) begin
         // advance to the trailing beat
         out_kind_ff <= pend_kind_ff;
         out_sx_ff   <= '0;
         out_sy_ff   <= '0;
         out_cnt_ff  <= pend_cnt_ff;
         out_el_ff   <= pend_el_ff;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_chan.event_kind  = out_kind_ff;
   assign rsp_chan.start_x     = out_sx_ff;
   assign rsp_chan.start_y     = out_sy_ff;
   assign rsp_chan.point_x     = px_ff;
   assign rsp_chan.point_y     = py_ff;
   assign rsp_chan.click_count = out_cnt_ff;
   assign rsp_chan.elapsed     = out_el_ff;
   assign rsp_chan.last_of_run = out_last_ff;

   `TGR_ASSERT_NEXT(a_take_leaves_idle, req_take, state_ff == tgr_pkg::ST_CALC, "take missed calc")
   `TGR_ASSERT_NOW(a_no_overlap, req_chan.ready, !rsp_chan.valid, "ready during result beat")
   `TGR_ASSERT_NEXT(a_last_ends_run, rsp_take && rsp_chan.last_of_run, !rsp_chan.valid, "no idle")
   `TGR_ASSERT_NOW(a_mul_in_mul_state, mul_busy, state_ff == tgr_pkg::ST_MUL, "mul outside state")
endmodule
